FILE: sv/rrts_pkg.sv
`default_nettype none

package rrts_pkg;

  localparam int unsigned NumSlots  = 16;
  localparam int unsigned SlotW     = $clog2(NumSlots);
  localparam int unsigned CountBits = 32;
  localparam int unsigned TickW     = 32;
  localparam int unsigned OpW       = 3;
  localparam int unsigned PortSlotW = 4;

  typedef enum logic [OpW-1:0] {
    OP_TICK   = 3'd0,
    OP_SLEEP  = 3'd1,
    OP_EXIT   = 3'd2,
    OP_CREATE = 3'd3,
    OP_ALARM  = 3'd4
  } op_e;

  typedef enum logic [1:0] {
    ST_UNUSED  = 2'd0,
    ST_READY   = 2'd1,
    ST_RUNNING = 2'd2,
    ST_WAITING = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    CU_PASS,
    CU_SLEEP_DEC,
    CU_ALARM_DEC,
    CU_SET_SLEEP,
    CU_SET_ALARM
  } cu_mode_e;

  typedef logic [CountBits-1:0] count_t;
  typedef logic [SlotW-1:0]     slot_t;

  typedef struct packed {
    count_t sleep_left;
    count_t alarm_period;
    count_t alarm_left;
  } row_t;

  typedef struct packed {
    logic  switched;
    slot_t old_slot;
    slot_t new_slot;
    logic  alarm_fire;
    logic  shutdown;
  } result_t;

  function automatic count_t clamp_count(logic [TickW-1:0] v);
    logic [TickW+CountBits-1:0] wide;
    logic [TickW+CountBits-1:0] lim;
    wide = {{CountBits{1'b0}}, v};
    lim  = {{TickW{1'b0}}, {CountBits{1'b1}}};
    if (wide > lim) begin
      return '1;
    end
    return wide[CountBits-1:0];
  endfunction

endpackage

`default_nettype wire

FILE: sv/rrts_cnt_unit.sv
`default_nettype none

module rrts_cnt_unit (
  input  rrts_pkg::cu_mode_e mode_i,
  input  rrts_pkg::row_t     row_i,
  input  rrts_pkg::count_t   cnt_i,
  output rrts_pkg::row_t     row_o,
  output logic               wake_o,
  output logic               fire_o
);

  rrts_pkg::count_t operand;
  rrts_pkg::count_t dec;

  // single shared decrementer for sleep and alarm counts
  always_comb begin
    operand = row_i.sleep_left;
    if (mode_i == rrts_pkg::CU_ALARM_DEC) begin
      operand = (row_i.alarm_left == '0) ? row_i.alarm_period : row_i.alarm_left;
    end
  end

  assign dec = operand - rrts_pkg::count_t'(1);

  always_comb begin
    row_o  = row_i;
    wake_o = 1'b0;
    fire_o = 1'b0;
    case (mode_i)
      rrts_pkg::CU_SLEEP_DEC: begin
        if (row_i.sleep_left != '0) begin
          row_o.sleep_left = dec;
          wake_o = (row_i.sleep_left == rrts_pkg::count_t'(1));
        end
      end
      rrts_pkg::CU_ALARM_DEC: begin
        if (row_i.alarm_period != '0) begin
          row_o.alarm_left = dec;
          fire_o = (row_i.alarm_left == '0);
        end
      end
      rrts_pkg::CU_SET_SLEEP: begin
        row_o.sleep_left = cnt_i;
      end
      rrts_pkg::CU_SET_ALARM: begin
        row_o.alarm_period = cnt_i;
        row_o.alarm_left   = cnt_i;
      end
      default: begin
        row_o = row_i;
      end
    endcase
  end

endmodule

`default_nettype wire

FILE: sv/rrts_seq.sv
`default_nettype none

module rrts_seq (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start_i,
  input  logic [rrts_pkg::OpW-1:0]           op_i,
  input  rrts_pkg::count_t                   cnt_i,
  input  logic [rrts_pkg::PortSlotW-1:0]     tgt_i,
  output logic                               busy_o,
  output logic                               res_valid_o,
  input  logic                               res_take_i,
  output rrts_pkg::result_t                  res_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_SEARCH,
    S_RD,
    S_WR,
    S_FIN,
    S_DONE
  } state_e;

  localparam int unsigned ScW = rrts_pkg::SlotW + 1;

  state_e             state_q, state_d;
  rrts_pkg::op_e      op_q, op_d;
  rrts_pkg::count_t   cnt_q, cnt_d;
  rrts_pkg::slot_t    tgt_q, tgt_d;
  logic               tgt_ok_q, tgt_ok_d;
  rrts_pkg::slot_t    cur_q, cur_d;
  rrts_pkg::slot_t    old_q, old_d;
  rrts_pkg::slot_t    found_slot_q, found_slot_d;
  logic               found_q, found_d;
  logic               wait_q, wait_d;
  logic               fire_q, fire_d;
  logic               down_q, down_d;
  logic [ScW-1:0]     sc_q, sc_d;
  rrts_pkg::slot_t    ptr_q, ptr_d;
  rrts_pkg::slot_t    k_q, k_d;

  rrts_pkg::status_e  status_q [rrts_pkg::NumSlots];
  rrts_pkg::slot_t    st_addr;
  rrts_pkg::status_e  st_rd;
  logic               st_we0, st_we1;
  rrts_pkg::slot_t    st_a0, st_a1;
  rrts_pkg::status_e  st_d0, st_d1;

  rrts_pkg::row_t     mem [rrts_pkg::NumSlots];
  logic [rrts_pkg::NumSlots-1:0] row_vld_q;
  rrts_pkg::row_t     rd_q;
  logic               rd_vld_q;
  rrts_pkg::slot_t    raddr, waddr;
  logic               mem_we;

  rrts_pkg::cu_mode_e cu_mode;
  rrts_pkg::row_t     cu_row_in, cu_row_out;
  logic               cu_wake, cu_fire;

  rrts_pkg::slot_t    scan_slot;
  rrts_pkg::slot_t    sleep_nxt;
  logic               found_now;

  assign st_rd     = status_q[st_addr];
  assign cu_row_in = rd_vld_q ? rd_q : '0;
  assign scan_slot = rrts_pkg::slot_t'(sc_q - ScW'(1));
  assign found_now = (ptr_q != '0) && (st_rd == rrts_pkg::ST_READY);
  assign sleep_nxt = found_q ? found_slot_q : '0;

  rrts_cnt_unit u_cnt (
    .mode_i (cu_mode),
    .row_i  (cu_row_in),
    .cnt_i  (cnt_q),
    .row_o  (cu_row_out),
    .wake_o (cu_wake),
    .fire_o (cu_fire)
  );

  always_comb begin
    state_d      = state_q;
    op_d         = op_q;
    cnt_d        = cnt_q;
    tgt_d        = tgt_q;
    tgt_ok_d     = tgt_ok_q;
    cur_d        = cur_q;
    old_d        = old_q;
    found_slot_d = found_slot_q;
    found_d      = found_q;
    wait_d       = wait_q;
    fire_d       = fire_q;
    down_d       = down_q;
    sc_d         = sc_q;
    ptr_d        = ptr_q;
    k_d          = k_q;
    st_addr      = cur_q;
    st_we0       = 1'b0;
    st_a0        = cur_q;
    st_d0        = rrts_pkg::ST_UNUSED;
    st_we1       = 1'b0;
    st_a1        = cur_q;
    st_d1        = rrts_pkg::ST_RUNNING;
    raddr        = cur_q;
    waddr        = cur_q;
    mem_we       = 1'b0;
    cu_mode      = rrts_pkg::CU_PASS;
    res_valid_o  = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          op_d     = rrts_pkg::op_e'(op_i);
          cnt_d    = cnt_i;
          tgt_d    = rrts_pkg::slot_t'(tgt_i);
          tgt_ok_d = (tgt_i != '0) && (32'(tgt_i) < rrts_pkg::NumSlots)
                     && (rrts_pkg::slot_t'(tgt_i) != cur_q);
          old_d    = cur_q;
          found_d  = 1'b0;
          wait_d   = 1'b0;
          fire_d   = 1'b0;
          down_d   = 1'b0;
          sc_d     = ScW'(1);
          k_d      = rrts_pkg::slot_t'(1);
          ptr_d    = (cur_q == rrts_pkg::slot_t'(rrts_pkg::NumSlots - 1)) ? '0
                     : cur_q + rrts_pkg::slot_t'(1);
          case (rrts_pkg::op_e'(op_i))
            rrts_pkg::OP_TICK: begin
              state_d = S_SCAN;
            end
            rrts_pkg::OP_SLEEP: begin
              st_we0  = 1'b1;
              st_d0   = rrts_pkg::ST_WAITING;
              state_d = S_RD;
            end
            rrts_pkg::OP_EXIT: begin
              st_we0  = 1'b1;
              st_d0   = rrts_pkg::ST_UNUSED;
              state_d = S_SEARCH;
            end
            rrts_pkg::OP_CREATE, rrts_pkg::OP_ALARM: begin
              state_d = S_RD;
            end
            default: begin
              state_d = S_DONE;
            end
          endcase
        end
      end

      // read slot sc while updating slot sc-1
      S_SCAN: begin
        if (sc_q < ScW'(rrts_pkg::NumSlots)) begin
          raddr = sc_q[rrts_pkg::SlotW-1:0];
        end
        st_addr = scan_slot;
        if (sc_q >= ScW'(2) && st_rd == rrts_pkg::ST_WAITING) begin
          cu_mode = rrts_pkg::CU_SLEEP_DEC;
          mem_we  = 1'b1;
          waddr   = scan_slot;
          if (cu_wake) begin
            st_we0 = 1'b1;
            st_a0  = scan_slot;
            st_d0  = rrts_pkg::ST_READY;
          end
        end
        sc_d = sc_q + ScW'(1);
        if (sc_q == ScW'(rrts_pkg::NumSlots)) begin
          state_d = S_SEARCH;
        end
      end

      S_SEARCH: begin
        st_addr = ptr_q;
        if (found_now) begin
          found_d      = 1'b1;
          found_slot_d = ptr_q;
        end
        if (ptr_q != '0 && st_rd == rrts_pkg::ST_WAITING) begin
          wait_d = 1'b1;
        end
        ptr_d = (ptr_q == rrts_pkg::slot_t'(rrts_pkg::NumSlots - 1)) ? '0
                : ptr_q + rrts_pkg::slot_t'(1);
        k_d   = k_q + rrts_pkg::slot_t'(1);
        if (found_now || k_q == rrts_pkg::slot_t'(rrts_pkg::NumSlots - 1)) begin
          state_d = (op_q == rrts_pkg::OP_TICK && !found_now) ? S_RD : S_FIN;
        end
      end

      S_RD: begin
        raddr   = cur_q;
        state_d = S_WR;
      end

      S_WR: begin
        state_d = S_DONE;
        case (op_q)
          rrts_pkg::OP_TICK: begin
            cu_mode = rrts_pkg::CU_ALARM_DEC;
            mem_we  = 1'b1;
            fire_d  = cu_fire;
          end
          rrts_pkg::OP_SLEEP: begin
            cu_mode = rrts_pkg::CU_SET_SLEEP;
            mem_we  = 1'b1;
            state_d = S_SEARCH;
          end
          rrts_pkg::OP_CREATE: begin
            if (tgt_ok_q) begin
              mem_we = 1'b1;
              waddr  = tgt_q;
              st_we0 = 1'b1;
              st_a0  = tgt_q;
              st_d0  = rrts_pkg::ST_READY;
            end
          end
          rrts_pkg::OP_ALARM: begin
            cu_mode = rrts_pkg::CU_SET_ALARM;
            mem_we  = 1'b1;
          end
          default: begin
            mem_we = 1'b0;
          end
        endcase
      end

      S_FIN: begin
        st_addr = cur_q;
        state_d = S_DONE;
        case (op_q)
          rrts_pkg::OP_TICK: begin
            if (st_rd == rrts_pkg::ST_RUNNING) begin
              st_we0 = 1'b1;
              st_d0  = rrts_pkg::ST_READY;
            end
            st_we1 = 1'b1;
            st_a1  = found_slot_q;
            cur_d  = found_slot_q;
          end
          rrts_pkg::OP_SLEEP: begin
            st_we1 = 1'b1;
            st_a1  = sleep_nxt;
            cur_d  = sleep_nxt;
          end
          rrts_pkg::OP_EXIT: begin
            if (found_q) begin
              st_we1 = 1'b1;
              st_a1  = found_slot_q;
              cur_d  = found_slot_q;
            end else if (wait_q) begin
              st_we1 = 1'b1;
              st_a1  = '0;
              cur_d  = '0;
            end else begin
              down_d = 1'b1;
            end
          end
          default: begin
            st_we1 = 1'b0;
          end
        endcase
      end

      S_DONE: begin
        res_valid_o = 1'b1;
        if (res_take_i) begin
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      op_q         <= rrts_pkg::OP_TICK;
      cnt_q        <= '0;
      tgt_q        <= '0;
      tgt_ok_q     <= 1'b0;
      cur_q        <= '0;
      old_q        <= '0;
      found_slot_q <= '0;
      found_q      <= 1'b0;
      wait_q       <= 1'b0;
      fire_q       <= 1'b0;
      down_q       <= 1'b0;
      sc_q         <= '0;
      ptr_q        <= '0;
      k_q          <= '0;
    end else begin
      state_q      <= state_d;
      op_q         <= op_d;
      cnt_q        <= cnt_d;
      tgt_q        <= tgt_d;
      tgt_ok_q     <= tgt_ok_d;
      cur_q        <= cur_d;
      old_q        <= old_d;
      found_slot_q <= found_slot_d;
      found_q      <= found_d;
      wait_q       <= wait_d;
      fire_q       <= fire_d;
      down_q       <= down_d;
      sc_q         <= sc_d;
      ptr_q        <= ptr_d;
      k_q          <= k_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < rrts_pkg::NumSlots; i++) begin
        status_q[i] <= (i == 0) ? rrts_pkg::ST_RUNNING : rrts_pkg::ST_UNUSED;
      end
    end else begin
      if (st_we0) begin
        status_q[st_a0] <= st_d0;
      end
      if (st_we1) begin
        status_q[st_a1] <= st_d1;
      end
    end
  end

  // count table: rows never written read as zero
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[waddr] <= cu_row_out;
    end
    rd_q <= mem[raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_vld_q <= '0;
      rd_vld_q  <= 1'b0;
    end else begin
      if (mem_we) begin
        row_vld_q[waddr] <= 1'b1;
      end
      rd_vld_q <= row_vld_q[raddr];
    end
  end

  assign busy_o           = (state_q != S_IDLE);
  assign res_o.switched   = (old_q != cur_q);
  assign res_o.old_slot   = old_q;
  assign res_o.new_slot   = cur_q;
  assign res_o.alarm_fire = fire_q;
  assign res_o.shutdown   = down_q;

endmodule

`default_nettype wire

FILE: sv/round_robin_task_scheduler.sv
// channel | valid      | stall      | payload
// in      | in_valid_i | in_stall_o | opcode_i, tick_count_i, target_slot_i
// out     | out_valid_o| out_stall_i| switched_o, old_slot_o, new_slot_o,
//         |            |            | alarm_fire_o, shutdown_o
//
// One item at a time.
// Tick: sleep count walk over all slots, search for the next ready slot, then switch or alarm update.
// Sleep and exit also search; create and set alarm update one row; unknown opcodes go straight to the result.
// Reset puts slot 0 running, all others unused, all counts zero; no clearing pass.
// A finished result sits in the output register and the next item is accepted
// meanwhile; a later result waits in the sequencer until that register frees up.
`default_nettype none

module round_robin_task_scheduler (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [2:0]  opcode_i,
  input  logic [31:0] tick_count_i,
  input  logic [3:0]  target_slot_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        switched_o,
  output logic [3:0]  old_slot_o,
  output logic [3:0]  new_slot_o,
  output logic        alarm_fire_o,
  output logic        shutdown_o
);

  logic              busy;
  logic              start;
  logic              res_valid;
  logic              res_take;
  rrts_pkg::result_t res;
  rrts_pkg::result_t out_res_q;
  logic              out_valid_q;

  assign in_stall_o = busy;
  assign start      = in_valid_i && !busy;
  assign res_take   = res_valid && (!out_valid_q || !out_stall_i);

  rrts_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start),
    .op_i        (opcode_i),
    .cnt_i       (rrts_pkg::clamp_count(tick_count_i)),
    .tgt_i       (target_slot_i),
    .busy_o      (busy),
    .res_valid_o (res_valid),
    .res_take_i  (res_take),
    .res_o       (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      out_res_q   <= '0;
    end else begin
      if (res_take) begin
        out_valid_q <= 1'b1;
        out_res_q   <= res;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o  = out_valid_q;
  assign switched_o   = out_res_q.switched;
  assign old_slot_o   = rrts_pkg::PortSlotW'(out_res_q.old_slot);
  assign new_slot_o   = rrts_pkg::PortSlotW'(out_res_q.new_slot);
  assign alarm_fire_o = out_res_q.alarm_fire;
  assign shutdown_o   = out_res_q.shutdown;

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("not busy after item accepted");

  a_fire_no_switch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && alarm_fire_o |-> !switched_o && !shutdown_o)
    else $error("alarm fired on a switch or shutdown");

  a_shutdown_no_switch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && shutdown_o |-> !switched_o && (old_slot_o == new_slot_o))
    else $error("shutdown with a task switch");

endmodule

`default_nettype wire

FILE: verif/round_robin_task_scheduler_tb.sv
`default_nettype none

module round_robin_task_scheduler_tb;
  timeunit 1ns;
  timeprecision 1ps;

  typedef logic [rrts_pkg::OpW-1:0] op_t;

  localparam op_t         OpUnknownLo = 3'd5;
  localparam op_t         OpUnknownHi = 3'd7;
  localparam int unsigned ScriptLen   = 27;

  logic                          clk_i;
  logic                          rst_ni;
  logic                          in_valid_i;
  logic                          in_stall_o;
  op_t                           opcode_i;
  logic [rrts_pkg::TickW-1:0]    tick_count_i;
  logic [3:0]                    target_slot_i;
  logic                          out_valid_o;
  logic                          out_stall_i;
  logic                          switched_o;
  logic [3:0]                    old_slot_o;
  logic [3:0]                    new_slot_o;
  logic                          alarm_fire_o;
  logic                          shutdown_o;

  round_robin_task_scheduler DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .opcode_i     (opcode_i),
    .tick_count_i (tick_count_i),
    .target_slot_i(target_slot_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .switched_o   (switched_o),
    .old_slot_o   (old_slot_o),
    .new_slot_o   (new_slot_o),
    .alarm_fire_o (alarm_fire_o),
    .shutdown_o   (shutdown_o)
  );

  typedef struct {
    op_t                        op;
    logic [rrts_pkg::TickW-1:0] cnt;
    logic [3:0]                 tgt;
    bit                         typed;
    rrts_pkg::result_t          want;
  } script_row_t;

  // scheduler shadow state
  rrts_pkg::status_e slot_st      [rrts_pkg::NumSlots];
  rrts_pkg::count_t  sleep_cnt    [rrts_pkg::NumSlots];
  rrts_pkg::count_t  alarm_reload [rrts_pkg::NumSlots];
  rrts_pkg::count_t  alarm_cnt    [rrts_pkg::NumSlots];
  rrts_pkg::slot_t   cur_task;

  rrts_pkg::result_t pending_switches[$];
  int                failures;
  bit                quiet_stretch;

  script_row_t opening_script [ScriptLen] = '{
    '{rrts_pkg::OP_TICK,   32'd0,         4'd0,  1'b1, '0},
    '{rrts_pkg::OP_ALARM,  32'd0,         4'd0,  1'b1, '0},
    '{rrts_pkg::OP_TICK,   32'hFFFF_FFFF, 4'd15, 1'b1, '0},
    '{rrts_pkg::OP_CREATE, 32'd0,         4'd0,  1'b1, '0},
    '{OpUnknownLo,         32'hFFFF_FFFF, 4'd15, 1'b1, '0},
    '{OpUnknownLo + 3'd1,  32'd5,         4'd3,  1'b1, '0},
    '{OpUnknownHi,         32'd0,         4'd15, 1'b1, '0},
    '{rrts_pkg::OP_EXIT,   32'd0,         4'd0,  1'b1, '{1'b0, 4'd0, 4'd0, 1'b0, 1'b1}},
    '{rrts_pkg::OP_CREATE, 32'd0,         4'd15, 1'b1, '0},
    '{rrts_pkg::OP_ALARM,  32'd2,         4'd0,  1'b1, '0},
    '{rrts_pkg::OP_TICK,   32'd0,         4'd0,  1'b1, '{1'b1, 4'd0, 4'd15, 1'b0, 1'b0}},
    '{rrts_pkg::OP_ALARM,  32'hFFFF_FFFF, 4'd0,  1'b0, '0},
    '{rrts_pkg::OP_ALARM,  32'd1,         4'd0,  1'b0, '0},
    '{rrts_pkg::OP_TICK,   32'd0,         4'd0,  1'b0, '0},
    '{rrts_pkg::OP_TICK,   32'd0,         4'd0,  1'b0, '0},
    '{rrts_pkg::OP_CREATE, 32'd0,         4'd15, 1'b1, '{1'b0, 4'd15, 4'd15, 1'b0, 1'b0}},
    '{rrts_pkg::OP_CREATE, 32'd0,         4'd1,  1'b0, '0},
    '{rrts_pkg::OP_SLEEP,  32'd0,         4'd0,  1'b0, '0},
    '{rrts_pkg::OP_SLEEP,  32'd2,         4'd0,  1'b0, '0},
    '{rrts_pkg::OP_SLEEP,  32'd3,         4'd0,  1'b0, '0},
    '{rrts_pkg::OP_TICK,   32'd0,         4'd0,  1'b0, '0},
    '{rrts_pkg::OP_TICK,   32'd0,         4'd0,  1'b0, '0},
    '{rrts_pkg::OP_EXIT,   32'd0,         4'd0,  1'b0, '0},
    '{rrts_pkg::OP_CREATE, 32'd0,         4'd15, 1'b0, '0},
    '{rrts_pkg::OP_TICK,   32'd0,         4'd0,  1'b0, '0},
    '{rrts_pkg::OP_EXIT,   32'd0,         4'd0,  1'b0, '0},
    '{rrts_pkg::OP_TICK,   32'd0,         4'd0,  1'b0, '0}
  };

  always #5 clk_i = ~clk_i;

  function automatic void reset_scheduler();
    foreach (slot_st[i]) begin
      slot_st[i]      = rrts_pkg::ST_UNUSED;
      sleep_cnt[i]    = '0;
      alarm_reload[i] = '0;
      alarm_cnt[i]    = '0;
    end
    slot_st[0] = rrts_pkg::ST_RUNNING;
    cur_task   = '0;
  endfunction

  // first ready slot after 'from', skipping the idle slot; -1 if none
  function automatic int next_ready(rrts_pkg::slot_t from, output bit saw_wait);
    int idx;
    saw_wait = 1'b0;
    for (int k = 1; k < int'(rrts_pkg::NumSlots); k++) begin
      idx = (int'(from) + k) % int'(rrts_pkg::NumSlots);
      if (idx != 0) begin
        if (slot_st[idx] == rrts_pkg::ST_READY) return idx;
        if (slot_st[idx] == rrts_pkg::ST_WAITING) saw_wait = 1'b1;
      end
    end
    return -1;
  endfunction

  function automatic rrts_pkg::result_t predict_switch(op_t op, rrts_pkg::count_t cnt,
                                                       rrts_pkg::slot_t tgt);
    rrts_pkg::result_t res;
    rrts_pkg::slot_t   prev;
    int                found;
    bit                saw_wait;
    prev = cur_task;
    res  = '0;
    case (op)
      rrts_pkg::OP_TICK: begin
        for (int i = 1; i < int'(rrts_pkg::NumSlots); i++) begin
          if (slot_st[i] == rrts_pkg::ST_WAITING && sleep_cnt[i] != '0) begin
            sleep_cnt[i] = sleep_cnt[i] - rrts_pkg::count_t'(1);
            if (sleep_cnt[i] == '0) slot_st[i] = rrts_pkg::ST_READY;
          end
        end
        found = next_ready(prev, saw_wait);
        if (found >= 0) begin
          if (slot_st[prev] == rrts_pkg::ST_RUNNING) slot_st[prev] = rrts_pkg::ST_READY;
          cur_task = rrts_pkg::slot_t'(found);
          slot_st[found] = rrts_pkg::ST_RUNNING;
        end else if (alarm_reload[prev] != '0) begin
          if (alarm_cnt[prev] == '0) begin
            alarm_cnt[prev] = alarm_reload[prev];
            res.alarm_fire  = 1'b1;
          end
          alarm_cnt[prev] = alarm_cnt[prev] - rrts_pkg::count_t'(1);
        end
      end
      rrts_pkg::OP_SLEEP: begin
        sleep_cnt[prev] = cnt;
        slot_st[prev]   = rrts_pkg::ST_WAITING;
        found = next_ready(prev, saw_wait);
        cur_task = (found >= 0) ? rrts_pkg::slot_t'(found) : '0;
        slot_st[cur_task] = rrts_pkg::ST_RUNNING;
      end
      rrts_pkg::OP_EXIT: begin
        slot_st[prev] = rrts_pkg::ST_UNUSED;
        found = next_ready(prev, saw_wait);
        if (found >= 0) begin
          cur_task = rrts_pkg::slot_t'(found);
          slot_st[found] = rrts_pkg::ST_RUNNING;
        end else if (saw_wait) begin
          cur_task   = '0;
          slot_st[0] = rrts_pkg::ST_RUNNING;
        end else begin
          res.shutdown = 1'b1;
        end
      end
      rrts_pkg::OP_CREATE: begin
        if (tgt != '0 && tgt != prev) begin
          slot_st[tgt]      = rrts_pkg::ST_READY;
          sleep_cnt[tgt]    = sleep_cnt[prev];
          alarm_reload[tgt] = alarm_reload[prev];
          alarm_cnt[tgt]    = alarm_cnt[prev];
        end
      end
      rrts_pkg::OP_ALARM: begin
        alarm_reload[prev] = cnt;
        alarm_cnt[prev]    = cnt;
      end
      default: ;
    endcase
    res.switched = (cur_task != prev);
    res.old_slot = prev;
    res.new_slot = cur_task;
    return res;
  endfunction

  // entered and left at a falling edge
  task automatic send_event(op_t op, logic [rrts_pkg::TickW-1:0] cnt, logic [3:0] tgt,
                            bit typed, rrts_pkg::result_t want);
    int                gap;
    rrts_pkg::result_t res;
    gap = quiet_stretch ? 0 : $urandom_range(11, 0);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i    <= 1'b1;
    opcode_i      <= op;
    tick_count_i  <= cnt;
    target_slot_i <= tgt;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    res = predict_switch(op, cnt, rrts_pkg::slot_t'(tgt));
    pending_switches.push_back(typed ? want : res);
    @(negedge clk_i);
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (pending_switches.size() != 0) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic send_random_events(int n, int tick_pct);
    int                         pick;
    op_t                        op;
    logic [rrts_pkg::TickW-1:0] cnt;
    logic [3:0]                 tgt;
    repeat (n) begin
      pick = $urandom_range(99, 0);
      tgt  = 4'($urandom_range(15, 1));
      if ($urandom_range(19, 0) == 0) tgt = 4'($urandom);
      cnt  = $urandom_range(6, 0);
      if ($urandom_range(9, 0) == 0) cnt = $urandom;
      if (pick < tick_pct) op = rrts_pkg::OP_TICK;
      else if (pick < tick_pct + 15) op = rrts_pkg::OP_SLEEP;
      else if (pick < tick_pct + 25) op = rrts_pkg::OP_EXIT;
      else if (pick < tick_pct + 50) op = rrts_pkg::OP_CREATE;
      else if (pick < 96) op = rrts_pkg::OP_ALARM;
      else op = op_t'($urandom_range(OpUnknownHi, OpUnknownLo));
      send_event(op, cnt, tgt, 1'b0, '0);
    end
  endtask

  always @(posedge clk_i) begin
    rrts_pkg::result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_switches.size() == 0) begin
        $error("unexpected item: old_slot %0d new_slot %0d", old_slot_o, new_slot_o);
        failures++;
      end else begin
        want = pending_switches.pop_front();
        if (switched_o !== want.switched) begin
          $error("switched: expected %0d, got %0d", want.switched, switched_o);
          failures++;
        end
        if (old_slot_o !== want.old_slot) begin
          $error("old_slot: expected %0d, got %0d", want.old_slot, old_slot_o);
          failures++;
        end
        if (new_slot_o !== want.new_slot) begin
          $error("new_slot: expected %0d, got %0d", want.new_slot, new_slot_o);
          failures++;
        end
        if (alarm_fire_o !== want.alarm_fire) begin
          $error("alarm_fire: expected %0d, got %0d", want.alarm_fire, alarm_fire_o);
          failures++;
        end
        if (shutdown_o !== want.shutdown) begin
          $error("shutdown: expected %0d, got %0d", want.shutdown, shutdown_o);
          failures++;
        end
      end
    end
  end

  // result side back-pressure, one draw per item
  initial begin
    int hold;
    out_stall_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      hold = quiet_stretch ? 0 : $urandom_range(11, 0);
      if (hold > 0) begin
        out_stall_i <= 1'b1;
        repeat (hold) @(negedge clk_i);
      end
      out_stall_i <= 1'b0;
      @(posedge clk_i);
      while (!out_valid_o) @(posedge clk_i);
    end
  end

  initial begin
    clk_i         = 1'b0;
    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    opcode_i      = rrts_pkg::OP_TICK;
    tick_count_i  = '0;
    target_slot_i = '0;
    failures      = 0;
    quiet_stretch = 1'b0;
    reset_scheduler();
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    foreach (opening_script[i]) begin
      send_event(opening_script[i].op, opening_script[i].cnt, opening_script[i].tgt,
                 opening_script[i].typed, opening_script[i].want);
    end
    drain_results();

    for (int phase = 0; phase < 7; phase++) begin
      quiet_stretch = (phase == 2 || phase == 5);
      send_random_events(150, 20 + 8 * phase);
      drain_results();
    end
    quiet_stretch = 1'b0;

    repeat (64) @(posedge clk_i);
    if (failures == 0) begin
      $display("round_robin_task_scheduler verification clean");
    end else begin
      $display("round_robin_task_scheduler verification failed");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("round_robin_task_scheduler verification failed");
    $finish;
  end

endmodule

`default_nettype wire
